@@ sv/qpd_pkg.sv @@
// ============================================================================
// qpd_pkg: shared types and constants of the quoted-printable decoder
// Item layouts for both channels, escape state codes and character codes.
// ============================================================================
package qpd_pkg;

    // Most results that one input item can cause.
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    // Character codes used by the decoder.
    localparam logic [7:0] C_EQ    = 8'h3D;  // '='
    localparam logic [7:0] C_BANG  = 8'h21;  // '!'
    localparam logic [7:0] C_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;

    // Escape state between items.
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,  // normal text
        MODE_EQ   = 2'd1,  // "=" seen
        MODE_HEX  = 2'd2,  // "=" and one hex digit seen
        MODE_CR   = 2'd3   // "=" and CR seen
    } t_mode;

    // One encoded input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in;

    // One decoded result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
    } t_out;

    typedef t_out [MAX_RES-1:0] t_res_list;

    // All results of one input item, oldest in slot 0.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        t_res_list        res;
    } t_batch;

endpackage

@@ sv/qpd_stream_if.sv @@
// ============================================================================
// qpd_stream_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ============================================================================
interface qpd_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/qpd_decode.sv @@
// ============================================================================
// qpd_decode: escape decoder for one encoded byte
// Maps the byte, the end flag and the escape state to the list of result
// items and the next escape state.
// ============================================================================
module qpd_decode (
    input  qpd_pkg::t_in   i_item,
    input  qpd_pkg::t_mode i_mode,
    input  logic [7:0]     i_held,
    output qpd_pkg::t_batch o_batch,
    output qpd_pkg::t_mode o_mode,
    output logic [7:0]     o_held
);
    import qpd_pkg::*;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Only called on hex digits; letters of either case share the low nibble.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    logic [7:0]       c;
    logic             c_pass;
    logic [CNT_W-1:0] n;
    t_res_list        res;
    t_mode            nmode;
    logic [7:0]       nheld;

    assign c      = i_item.in_byte;
    assign c_pass = (c >= C_BANG) && (c <= C_TILDE) && (c != C_EQ);

    always_comb begin
        n     = '0;
        res   = '0;
        nmode = MODE_TEXT;
        nheld = i_held;

        case (i_mode)
            MODE_TEXT: begin
                if (c == C_EQ) begin
                    nmode = MODE_EQ;
                end else if (c_pass) begin
                    res[n[IDX_W-1:0]] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
                    n = n + 1'b1;
                end
            end
            MODE_EQ: begin
                if (is_hex(c)) begin
                    nheld = c;
                    nmode = MODE_HEX;
                end else if (c == C_CR) begin
                    nmode = MODE_CR;
                end else if (c_pass) begin
                    res[0] = '{out_byte: C_EQ, has_byte: 1'b1, default: 1'b0};
                    res[1] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
                    n = 2'd2;
                end
                // A line feed is a soft break; anything else is dropped.
            end
            MODE_HEX: begin
                if (is_hex(c)) begin
                    res[0] = '{out_byte: {hex_val(i_held), hex_val(c)}, has_byte: 1'b1,
                               default: 1'b0};
                    n = 2'd1;
                end else begin
                    // Broken pair: give "=" and the digit, then treat this byte as text.
                    res[0] = '{out_byte: C_EQ, has_byte: 1'b1, default: 1'b0};
                    res[1] = '{out_byte: i_held, has_byte: 1'b1, default: 1'b0};
                    n = 2'd2;
                    if (c == C_EQ) begin
                        nmode = MODE_EQ;
                    end else if (c_pass) begin
                        res[2] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
                        n = 2'd3;
                    end
                end
            end
            MODE_CR: begin
                if (c != C_LF) begin
                    if (c == C_EQ) begin
                        nmode = MODE_EQ;
                    end else if (c_pass) begin
                        res[0] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
                        n = 2'd1;
                    end
                end
            end
            default: begin
                nmode = MODE_TEXT;
            end
        endcase

        if (i_item.last) begin
            // A pending hex digit is flushed as "=" and the digit.
            if (nmode == MODE_HEX) begin
                res[n[IDX_W-1:0]] = '{out_byte: C_EQ, has_byte: 1'b1, default: 1'b0};
                n = n + 1'b1;
                res[n[IDX_W-1:0]] = '{out_byte: nheld, has_byte: 1'b1, default: 1'b0};
                n = n + 1'b1;
            end
            nmode = MODE_TEXT;
            nheld = '0;
            if (n == '0) begin
                res[0] = '0;
                n = 2'd1;
            end
        end

        if (n != '0) begin
            res[n[IDX_W-1:0] - 1'b1].run_last   = 1'b1;
            res[n[IDX_W-1:0] - 1'b1].stream_end = i_item.last;
        end
    end

    assign o_batch = '{cnt: n, res: res};
    assign o_mode  = nmode;
    assign o_held  = nheld;

endmodule

@@ sv/qpd_outbuf.sv @@
// ============================================================================
// qpd_outbuf: result buffer and output register
// Holds the results of one input item and hands them out one per cycle while the output is ready.
// ============================================================================
module qpd_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  qpd_pkg::t_batch i_batch,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output qpd_pkg::t_out   o_out_data,
    output logic            o_load_ok
);
    import qpd_pkg::*;

    t_res_list        r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign pop         = (r_cnt != '0) && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[0];
    // A new batch may enter when the buffer is empty or its last item leaves now.
    assign o_load_ok   = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_batch.res;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule

@@ sv/quoted_printable_decoder.sv @@
// ============================================================================
// quoted_printable_decoder: tolerant quoted-printable byte decoder
// Turns an encoded byte stream into decoded bytes, one encoded byte per item.
// ============================================================================
//
//   Channel  Role    Item                         Handshake
//   -------  ------  ---------------------------  -----------------
//   i_in     sink    in_byte, last                valid/ready
//   o_out    source  out_byte, has_byte,          valid/ready
//                    run_last, stream_end
//
// An input item is decoded in the cycle it is accepted and its results
// appear at the output in the next cycle. The three-slot result buffer
// drains one result per cycle while the output is ready, and the input
// is held until the last buffered result of an item leaves; the next item
// can be taken in the cycle that result leaves. Reset is synchronous and
// active low; it empties the buffer and returns the escape state to normal
// text. Stalls on the output hold the current result and the input waits.
//
// Decoding rules: "=" and two hex digits give one byte; "=" and CR LF or
// LF is a soft break; "=" and any other visible character but "=" give both
// characters; visible characters (21h to 7Eh) other than "=" pass; all other
// bytes are dropped. A broken hex pair gives "=" and the first digit, and the
// breaking byte is then decoded as text. The last item of a stream flushes
// a pending digit, clears the escape state and always tags its final
// result with stream_end, adding a bare marker result if it gave none.
// ============================================================================
module quoted_printable_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qpd_stream_if.sink    i_in,
    qpd_stream_if.source  o_out
);
    import qpd_pkg::*;

    // Escape state carried between items.
    t_mode      r_mode;
    logic [7:0] r_held;

    t_mode      n_mode;
    logic [7:0] n_held;
    t_batch     batch;
    logic       load_ok;
    logic       accept;

    assign accept     = i_in.valid && load_ok;
    assign i_in.ready = load_ok;

    qpd_decode u_decode (
        .i_item  (i_in.data),
        .i_mode  (r_mode),
        .i_held  (r_held),
        .o_batch (batch),
        .o_mode  (n_mode),
        .o_held  (n_held)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_held <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

    // Results of the accepted item go to the buffer, which also serves
    // as the output register.
    qpd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_batch     (batch),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .o_load_ok   (load_ok)
    );

endmodule

@@ sv/qpd_checker.sv @@
// ============================================================================
// qpd_checker: port-level checks of the quoted-printable decoder
// Watches both channels and flags behavior the decoder must never show.
// ============================================================================
module qpd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input qpd_pkg::t_in  i_in_data,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input qpd_pkg::t_out i_out_data
);
    import qpd_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output item changed while stalled");

    // The input only waits while results are pending.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // The end of a stream always yields at least one result.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_data.last |=> i_out_valid)
        else $error("stream end gave no result");

    // Stream end is only on the final result of an item.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.stream_end |-> i_out_data.run_last)
        else $error("stream_end without run_last");

    // A bare marker carries a zero byte and closes the stream.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.has_byte |->
            i_out_data.stream_end && (i_out_data.out_byte == 8'h00))
        else $error("malformed end marker");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_data   (i_in.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
